// ----- rtl/core/iss_pkg.sv -----
// shared types and constants for the indexed sequence store
package iss_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 7;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- rtl/core/iss_in_if.sv -----
// request channel: command, index and value with valid/ready
interface iss_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         command;
  logic [iss_pkg::IDX_W-1:0]          index;
  logic signed [iss_pkg::DATA_W-1:0]  value;

  modport source (output valid, output command, output index, output value, input ready);
  modport sink   (input valid, input command, input index, input value, output ready);
endinterface

// ----- rtl/core/iss_out_if.sv -----
// result channel: read value, status and count with valid/ready
interface iss_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [iss_pkg::DATA_W-1:0]  read_value;
  logic [1:0]                         status;
  logic [iss_pkg::CNT_W-1:0]          count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

// ----- rtl/core/iss_ram.sv -----
// simple dual-port ram, one write and one registered read per cycle
module iss_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/indexed_sequence_store_top.sv -----
// top level of the indexed sequence store: request sequencer over one element ram
//
// Holds up to iss_pkg::CAPACITY 32-bit elements in order in a single ram with one
// write port and one registered read port; there is no clearing pass after reset,
// the store is empty at once. One request is handled at a time and in_ch.ready is
// high only while the sequencer is idle. Inserts and deletes run an element move
// loop: each moved element is one ram read followed by one ram write, from the
// S_INS_CHECK/S_DEL_CHECK state to the S_INS_WR/S_DEL_WR state. The finished
// result sits in an output register, so the next request is taken while it waits
// for out_ch.ready.
module indexed_sequence_store_top (
  input  logic       clk,
  input  logic       rst_n,
  iss_in_if.sink     in_ch,
  iss_out_if.source  out_ch
);

  localparam int AW = iss_pkg::ADDR_W;
  localparam int CW = iss_pkg::CNT_W;
  localparam int DW = iss_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_WR,
    S_DEL_CHECK,
    S_DEL_WR,
    S_RD,
    S_RD_DATA,
    S_FINISH
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          count_r;
  logic [AW-1:0]          ptr_r;
  logic [AW-1:0]          pos_r;
  logic [DW-1:0]          val_r;
  logic [DW-1:0]          res_value_r;
  iss_pkg::status_t       res_status_r;

  logic                   out_valid_r;
  logic signed [DW-1:0]   out_value_r;
  logic [1:0]             out_status_r;
  logic [CW-1:0]          out_count_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [DW-1:0]          ram_rdata;

  logic                   in_beat;
  logic                   full;
  logic [CW-1:0]          in_idx;
  logic [CW-1:0]          ptr_inc;
  logic                   out_free;
  iss_pkg::status_t       dec_status;
  state_t                 dec_state;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(iss_pkg::CAPACITY));
  assign in_idx      = CW'(in_ch.index);
  assign ptr_inc     = CW'({1'b0, ptr_r}) + CW'(1);
  assign out_free    = !out_valid_r || out_ch.ready;

  // request decode: range test wins over the full test on insert
  always_comb begin
    dec_status = iss_pkg::ST_DONE;
    dec_state  = S_FINISH;
    case (in_ch.command)
      iss_pkg::CMD_APPEND: begin
        if (full) begin
          dec_status = iss_pkg::ST_FULL;
        end else begin
          dec_state = S_INS_CHECK;
        end
      end
      iss_pkg::CMD_INSERT: begin
        if (in_idx > count_r) begin
          dec_status = iss_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = iss_pkg::ST_FULL;
        end else begin
          dec_state = S_INS_CHECK;
        end
      end
      iss_pkg::CMD_DELETE: begin
        if (in_idx >= count_r) begin
          dec_status = iss_pkg::ST_RANGE;
        end else begin
          dec_state = S_DEL_CHECK;
        end
      end
      default: begin
        if (in_idx >= count_r) begin
          dec_status = iss_pkg::ST_RANGE;
        end else begin
          dec_state = S_RD;
        end
      end
    endcase
  end

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = ram_rdata;
    ram_raddr = pos_r;
    case (state_r)
      S_INS_CHECK: begin
        ram_raddr = ptr_r - AW'(1);
        if (ptr_r == pos_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = val_r;
        end
      end
      S_INS_WR: begin
        ram_we = 1'b1;
      end
      S_DEL_CHECK: begin
        ram_raddr = ptr_r + AW'(1);
      end
      S_DEL_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  iss_ram #(
    .DEPTH (iss_pkg::CAPACITY),
    .WIDTH (DW),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a finishing request reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            val_r        <= in_ch.value;
            res_value_r  <= '0;
            res_status_r <= dec_status;
            pos_r        <= (in_ch.command == iss_pkg::CMD_APPEND) ? AW'(count_r)
                                                                   : AW'(in_ch.index);
            ptr_r        <= (in_ch.command == iss_pkg::CMD_DELETE) ? AW'(in_ch.index)
                                                                   : AW'(count_r);
            state_r      <= dec_state;
          end
        end
        S_INS_CHECK: begin
          // at the slot: value is written by the ram steering this cycle
          if (ptr_r == pos_r) begin
            count_r <= count_r + CW'(1);
            state_r <= S_FINISH;
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          ptr_r   <= ptr_r - AW'(1);
          state_r <= S_INS_CHECK;
        end
        S_DEL_CHECK: begin
          if (ptr_inc == count_r) begin
            count_r <= count_r - CW'(1);
            state_r <= S_FINISH;
          end else begin
            state_r <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          ptr_r   <= ptr_r + AW'(1);
          state_r <= S_DEL_CHECK;
        end
        S_RD: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_value_r <= ram_rdata;
          state_r     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.count      = out_count_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(iss_pkg::CAPACITY))
    else $error("element count above capacity");

  a_ins_shift_above_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |-> (ptr_r > pos_r))
    else $error("insert move below the target slot");

  a_del_shift_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_WR) |-> (ptr_inc < count_r))
    else $error("delete move past the last element");

  a_finish_loads_output : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && out_count_r == count_r))
    else $error("finished result not loaded into output register");
`endif

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench for the indexed sequence store top level
module tb_top;

  typedef struct {
    logic signed [iss_pkg::DATA_W-1:0] read_value;
    iss_pkg::status_t                  status;
    logic [iss_pkg::CNT_W-1:0]         count;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iss_in_if  in_ch ();
  iss_out_if out_ch ();

  indexed_sequence_store_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // predicted contents of the store
  logic signed [iss_pkg::DATA_W-1:0] seq_cells [iss_pkg::CAPACITY];
  int                                seq_count;
  result_t                           pending_results [$];

  int fail_count;
  int checked_count;
  int sent_count;
  int peak_count;
  int full_rejects;
  int range_rejects;
  int sent_per_cmd [4];
  int send_mode;
  int recv_mode;

  // 0: never idle, 1: idle now and then, 2: a random gap, possibly none, before every beat
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic signed [iss_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // mostly a legal position below limit, otherwise anything from limit up
  function automatic logic [iss_pkg::IDX_W-1:0] pick_index(int limit);
    if (limit > 0 && $urandom_range(0, 99) < 85)
      return iss_pkg::IDX_W'($urandom_range(0, limit - 1));
    return iss_pkg::IDX_W'($urandom_range(limit, 127));
  endfunction

  function automatic result_t predict_request(iss_pkg::cmd_t cmd,
                                              logic [iss_pkg::IDX_W-1:0] idx,
                                              logic signed [iss_pkg::DATA_W-1:0] val);
    result_t r;
    int      pos;
    int      k;
    r.read_value = '0;
    r.status     = iss_pkg::ST_DONE;
    case (cmd)
      iss_pkg::CMD_APPEND, iss_pkg::CMD_INSERT: begin
        pos = (cmd == iss_pkg::CMD_APPEND) ? seq_count : int'(idx);
        // index test first, so a bad index on a full store reports range
        if (pos > seq_count) begin
          r.status = iss_pkg::ST_RANGE;
        end else if (seq_count >= iss_pkg::CAPACITY) begin
          r.status = iss_pkg::ST_FULL;
        end else begin
          for (k = seq_count; k > pos; k--)
            seq_cells[k] = seq_cells[k - 1];
          seq_cells[pos] = val;
          seq_count++;
        end
      end
      iss_pkg::CMD_DELETE: begin
        if (int'(idx) >= seq_count) begin
          r.status = iss_pkg::ST_RANGE;
        end else begin
          for (k = int'(idx); k + 1 < seq_count; k++)
            seq_cells[k] = seq_cells[k + 1];
          seq_count--;
        end
      end
      default: begin
        if (int'(idx) >= seq_count)
          r.status = iss_pkg::ST_RANGE;
        else
          r.read_value = seq_cells[idx];
      end
    endcase
    r.count = iss_pkg::CNT_W'(seq_count);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_request(iss_pkg::cmd_t cmd, logic [iss_pkg::IDX_W-1:0] idx,
                              logic signed [iss_pkg::DATA_W-1:0] val);
    int      gap;
    result_t exp;
    if (sent_count % 40 == 0)
      send_mode = $urandom_range(0, 2);
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.command = cmd;
    in_ch.index   = idx;
    in_ch.value   = val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    exp = predict_request(cmd, idx, val);
    pending_results.push_back(exp);
    sent_count++;
    sent_per_cmd[cmd]++;
    if (exp.status == iss_pkg::ST_FULL)
      full_rejects++;
    if (exp.status == iss_pkg::ST_RANGE)
      range_rejects++;
    if (seq_count > peak_count)
      peak_count = seq_count;
    @(negedge clk);
  endtask

  // result side: random stalls, compare against the oldest prediction
  initial begin : result_checker
    result_t exp;
    int      stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (checked_count % 40 == 0)
        recv_mode = $urandom_range(0, 2);
      stall = draw_gap(recv_mode);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("tb: result beat with nothing expected: read_value %h status %0d count %0d",
                   out_ch.read_value, out_ch.status, out_ch.count);
      end else begin
        exp = pending_results.pop_front();
        if (out_ch.read_value !== exp.read_value || out_ch.status !== exp.status ||
            out_ch.count !== exp.count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("tb: mismatch on result %0d: read_value %h/%h status %0d/%0d count %0d/%0d",
                     checked_count, exp.read_value, out_ch.read_value, exp.status,
                     out_ch.status, exp.count, out_ch.count);
        end
      end
      checked_count++;
      @(negedge clk);
    end
  end

  task automatic test_empty_store();
    send_request(iss_pkg::CMD_READ, 0, '0);
    send_request(iss_pkg::CMD_DELETE, 0, '0);
    send_request(iss_pkg::CMD_INSERT, 1, 32'sd5);
    send_request(iss_pkg::CMD_READ, 127, -32'sd1);
    send_request(iss_pkg::CMD_DELETE, 127, '0);
  endtask

  task automatic test_edit_ops();
    int i;
    send_request(iss_pkg::CMD_APPEND, 0, 32'sh8000_0000);
    send_request(iss_pkg::CMD_APPEND, 127, 32'sh7fff_ffff);
    send_request(iss_pkg::CMD_INSERT, 0, '0);
    // insert at the count acts as an append
    send_request(iss_pkg::CMD_INSERT, 3, -32'sd1);
    send_request(iss_pkg::CMD_INSERT, 1, pick_value());
    for (i = 0; i < 6; i++)
      send_request(iss_pkg::CMD_READ, iss_pkg::IDX_W'(i), '0);
    send_request(iss_pkg::CMD_DELETE, 2, '0);
    send_request(iss_pkg::CMD_DELETE, 3, '0);
    send_request(iss_pkg::CMD_DELETE, 3, '0);
    send_request(iss_pkg::CMD_READ, 64, '0);
  endtask

  task automatic test_full_store();
    while (seq_count > 0)
      send_request(iss_pkg::CMD_DELETE, iss_pkg::IDX_W'(seq_count - 1), $urandom);
    while (seq_count < iss_pkg::CAPACITY) begin
      if ($urandom_range(0, 1))
        send_request(iss_pkg::CMD_APPEND, iss_pkg::IDX_W'($urandom_range(0, 127)),
                     pick_value());
      else
        send_request(iss_pkg::CMD_INSERT, iss_pkg::IDX_W'($urandom_range(0, seq_count)),
                     pick_value());
    end
    send_request(iss_pkg::CMD_APPEND, 0, pick_value());
    send_request(iss_pkg::CMD_INSERT, 0, pick_value());
    // index equal to the count on a full store: rejected as full
    send_request(iss_pkg::CMD_INSERT, iss_pkg::IDX_W'(iss_pkg::CAPACITY), pick_value());
    send_request(iss_pkg::CMD_INSERT, iss_pkg::IDX_W'(iss_pkg::CAPACITY + 1), pick_value());
    send_request(iss_pkg::CMD_READ, iss_pkg::IDX_W'(iss_pkg::CAPACITY - 1), '0);
    send_request(iss_pkg::CMD_READ, iss_pkg::IDX_W'(iss_pkg::CAPACITY), '0);
    // longest moves in both directions
    send_request(iss_pkg::CMD_DELETE, 0, '0);
    send_request(iss_pkg::CMD_INSERT, 0, pick_value());
    send_request(iss_pkg::CMD_DELETE, iss_pkg::IDX_W'(iss_pkg::CAPACITY - 1), '0);
    send_request(iss_pkg::CMD_APPEND, 0, pick_value());
    while (seq_count > 0)
      send_request(iss_pkg::CMD_DELETE, iss_pkg::IDX_W'($urandom_range(0, seq_count - 1)),
                   $urandom);
    send_request(iss_pkg::CMD_DELETE, 0, '0);
  endtask

  task automatic test_random_mix(int n_items);
    int                        i;
    int                        bias;
    int                        roll;
    iss_pkg::cmd_t             cmd;
    logic [iss_pkg::IDX_W-1:0] idx;
    bias = 2;
    for (i = 0; i < n_items; i++) begin
      // phases that grow, shrink or churn the store
      if (i % 50 == 0)
        bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      case (bias)
        0: cmd = roll < 30 ? iss_pkg::CMD_APPEND : roll < 70 ? iss_pkg::CMD_INSERT :
                 roll < 80 ? iss_pkg::CMD_DELETE : iss_pkg::CMD_READ;
        1: cmd = roll < 10 ? iss_pkg::CMD_APPEND : roll < 20 ? iss_pkg::CMD_INSERT :
                 roll < 70 ? iss_pkg::CMD_DELETE : iss_pkg::CMD_READ;
        default: cmd = iss_pkg::cmd_t'(roll % 4);
      endcase
      case (cmd)
        iss_pkg::CMD_APPEND: idx = iss_pkg::IDX_W'($urandom_range(0, 127));
        iss_pkg::CMD_INSERT: idx = pick_index(seq_count + 1);
        default:             idx = pick_index(seq_count);
      endcase
      send_request(cmd, idx, pick_value());
    end
  endtask

  initial begin : main_flow
    int waited;
    in_ch.valid   = 1'b0;
    in_ch.command = iss_pkg::CMD_APPEND;
    in_ch.index   = '0;
    in_ch.value   = '0;
    rst_n         = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_store();
    test_edit_ops();
    test_full_store();
    test_random_mix(950);
    in_ch.valid = 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count += pending_results.size();
      $display("tb: %0d results never arrived", pending_results.size());
    end

    $display("tb: %0d requests (append %0d, insert %0d, delete %0d, read %0d), %0d results",
             sent_count, sent_per_cmd[iss_pkg::CMD_APPEND], sent_per_cmd[iss_pkg::CMD_INSERT],
             sent_per_cmd[iss_pkg::CMD_DELETE], sent_per_cmd[iss_pkg::CMD_READ],
             checked_count);
    $display("tb: peak fill %0d of %0d, %0d full rejections, %0d out-of-range requests",
             peak_count, iss_pkg::CAPACITY, full_rejects, range_rejects);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
